/* rtl/core/pinned_lru_page_cache_macros.svh */
// Assertion shorthands for the page cache RTL. Each expects clk and arst_n in scope.
`ifndef PINNED_LRU_PAGE_CACHE_MACROS_SVH
`define PINNED_LRU_PAGE_CACHE_MACROS_SVH

// Condition holds at every edge outside reset.
`define PLC_CHECK(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Same-cycle implication.
`define PLC_CHECK_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define PLC_CHECK_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/plc_pkg.sv */
package plc_pkg;
	localparam int FS_W   = 16;
	localparam int ID_W   = 32;
	localparam int DONE_W = 7;
	localparam int OP_W   = 4;
	localparam int ST_W   = 2;

	typedef enum logic [OP_W-1:0] {
		OP_GET        = 4'd0,
		OP_PUT        = 4'd1,
		OP_ADD        = 4'd2,
		OP_MARK       = 4'd3,
		OP_CLEAR      = 4'd4,
		OP_FLUSH_FILE = 4'd5,
		OP_FLUSH_ALL  = 4'd6,
		OP_INVAL      = 4'd7,
		OP_DISCARD    = 4'd8
	} op_t;

	typedef enum logic [ST_W-1:0] {
		ST_OK      = 2'd0,
		ST_MISS    = 2'd1,
		ST_PRESENT = 2'd2,
		ST_NOROOM  = 2'd3
	} status_t;

	localparam logic KIND_STATUS = 1'b0;
	localparam logic KIND_WB     = 1'b1;

	// controller -> datapath
	typedef struct packed {
		logic take;
		logic idx_clr;
		logic idx_inc;
		logic scan_rd;
		logic scan_ev;
		logic decide;
		logic sweep;
		logic upd_rd;
		logic upd_map;
		logic upd_wr;
		logic ins;
		logic fin;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic idx_last;
		logic ev_stall;
		logic need_upd;
		logic need_ins;
		logic out_free;
	} sts_t;
endpackage

/* rtl/core/plc_ctrl.sv */
module plc_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  plc_pkg::sts_t sts,
	output plc_pkg::cmd_t cmd
);
	import plc_pkg::*;

	typedef enum logic [9:0] {
		S_IDLE  = 10'b00_0000_0001,
		S_SRD   = 10'b00_0000_0010,
		S_SEV   = 10'b00_0000_0100,
		S_DEC   = 10'b00_0000_1000,
		S_SWP   = 10'b00_0001_0000,
		S_URD   = 10'b00_0010_0000,
		S_UMAP  = 10'b00_0100_0000,
		S_UWR   = 10'b00_1000_0000,
		S_INS   = 10'b01_0000_0000,
		S_FIN   = 10'b10_0000_0000
	} state_t;

	state_t state_q, state_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.take    = 1'b1;
					cmd.idx_clr = 1'b1;
					state_d     = S_SRD;
				end
			end
			S_SRD: begin
				cmd.scan_rd = 1'b1;
				state_d     = S_SEV;
			end
			S_SEV: begin
				cmd.scan_ev = 1'b1;
				if (!sts.ev_stall) begin
					if (sts.idx_last) begin
						state_d = S_DEC;
					end else begin
						cmd.idx_inc = 1'b1;
						state_d     = S_SRD;
					end
				end
			end
			S_DEC: begin
				cmd.decide  = 1'b1;
				cmd.idx_clr = 1'b1;
				if (sts.need_upd)
					state_d = S_SWP;
				else if (sts.need_ins)
					state_d = S_INS;
				else
					state_d = S_FIN;
			end
			S_SWP: begin
				cmd.sweep = 1'b1;
				if (sts.idx_last) begin
					cmd.idx_clr = 1'b1;
					state_d     = S_URD;
				end else begin
					cmd.idx_inc = 1'b1;
				end
			end
			S_URD: begin
				cmd.upd_rd = 1'b1;
				state_d    = S_UMAP;
			end
			S_UMAP: begin
				cmd.upd_map = 1'b1;
				state_d     = S_UWR;
			end
			S_UWR: begin
				cmd.upd_wr = 1'b1;
				if (sts.idx_last) begin
					state_d = sts.need_ins ? S_INS : S_FIN;
				end else begin
					cmd.idx_inc = 1'b1;
					state_d     = S_URD;
				end
			end
			S_INS: begin
				cmd.ins = 1'b1;
				state_d = S_FIN;
			end
			S_FIN: begin
				if (sts.out_free) begin
					cmd.fin = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end
endmodule

/* rtl/core/plc_datapath.sv */
`include "pinned_lru_page_cache_macros.svh"

module plc_datapath #(
	parameter int ENTRIES  = 64,
	parameter int PIN_BITS = 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  plc_pkg::cmd_t               cmd,
	output plc_pkg::sts_t               sts,
	input  logic [plc_pkg::OP_W-1:0]    op,
	input  logic [plc_pkg::FS_W-1:0]    fs_id,
	input  logic [plc_pkg::ID_W-1:0]    file_id,
	input  logic [plc_pkg::ID_W-1:0]    page_num,
	input  logic [plc_pkg::ID_W-1:0]    frame,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic                        kind,
	output logic [plc_pkg::ST_W-1:0]    status,
	output logic [plc_pkg::FS_W-1:0]    out_fs_id,
	output logic [plc_pkg::ID_W-1:0]    out_file_id,
	output logic [plc_pkg::ID_W-1:0]    out_page_num,
	output logic [plc_pkg::ID_W-1:0]    out_frame,
	output logic [plc_pkg::DONE_W-1:0]  done_count,
	output logic                        last
);
	import plc_pkg::*;

	localparam int IDX_W  = $clog2(ENTRIES);
	localparam int AGE_W  = IDX_W;
	localparam int OCC_W  = $clog2(ENTRIES + 1);
	localparam int META_W = 1 + PIN_BITS + AGE_W;
	localparam int KEY_W  = FS_W + 3 * ID_W;
	localparam int PIN_LO = AGE_W;
	localparam int DIRTY_BIT = AGE_W + PIN_BITS;
	localparam logic [PIN_BITS-1:0] PIN_MAX = {PIN_BITS{1'b1}};
	localparam logic [PIN_BITS-1:0] PIN_ONE = PIN_BITS'(1);
	localparam logic [AGE_W:0]      AGE_ONE = (AGE_W + 1)'(1);
	localparam logic [DONE_W-1:0]   DONE_ONE = DONE_W'(1);

	// latched request
	logic [OP_W-1:0] op_q;
	logic [FS_W-1:0] fs_q;
	logic [ID_W-1:0] file_q, page_q, frame_q;

	// storage
	logic [KEY_W-1:0]  key_mem   [ENTRIES];
	logic [META_W-1:0] meta_mem  [ENTRIES];
	logic [AGE_W-1:0]  remap_mem [ENTRIES];
	logic [KEY_W-1:0]  rdk_q;
	logic [META_W-1:0] rdm_q;
	logic [AGE_W-1:0]  rdr_q;
	logic [ENTRIES-1:0] valid_q;
	logic [OCC_W-1:0]  occ_q;

	logic [IDX_W-1:0] idx_q;

	// scan results
	logic             found_q, free_found_q, vfound_q;
	logic [IDX_W-1:0] sidx_q, free_idx_q, vidx_q, tgt_q;
	logic [AGE_W-1:0] sage_q, vage_q, ref_age_q;
	logic [ID_W-1:0]  hframe_q;
	logic             vdirty_q;
	logic [KEY_W-1:0] vkey_q;
	logic [DONE_W-1:0] total_q;
	logic [ENTRIES-1:0] dmask_q;
	logic [AGE_W:0]   run_q;
	logic [ST_W-1:0]  status_q;
	logic             evict_q;

	// held writeback beat, released once we know whether it is the final one
	logic              pend_v_q;
	logic [KEY_W-1:0]  pend_key_q;
	logic [DONE_W-1:0] pend_done_q;

	// output register
	logic              out_v_q;
	logic              out_kind_q, out_last_q;
	logic [ST_W-1:0]   out_st_q;
	logic [KEY_W-1:0]  out_key_q;
	logic [DONE_W-1:0] out_done_q;

	// read word fields
	logic [FS_W-1:0]     rd_fs;
	logic [ID_W-1:0]     rd_file, rd_page, rd_frame;
	logic                rd_dirty;
	logic [PIN_BITS-1:0] rd_pin;
	logic [AGE_W-1:0]    rd_age;

	assign {rd_fs, rd_file, rd_page, rd_frame} = rdk_q;
	assign rd_age   = rdm_q[AGE_W-1:0];
	assign rd_pin   = rdm_q[PIN_LO +: PIN_BITS];
	assign rd_dirty = rdm_q[DIRTY_BIT];

	// scan evaluation
	logic ent_v, fh, kh, is_flush, is_drop, key_op, sel, act, wb_now;
	logic ev_stall, ev_go, load_scan;

	assign ent_v    = valid_q[idx_q];
	assign fh       = ent_v && (rd_fs == fs_q) && (rd_file == file_q);
	assign kh       = fh && (rd_page == page_q);
	assign is_flush = (op_q == OP_FLUSH_FILE) || (op_q == OP_FLUSH_ALL);
	assign is_drop  = (op_q == OP_INVAL) || (op_q == OP_DISCARD);
	assign key_op   = op_q inside {OP_GET, OP_PUT, OP_MARK, OP_CLEAR};
	assign sel      = (op_q == OP_FLUSH_ALL) ? ent_v : fh;
	assign act      = sel && ((is_flush && rd_dirty) || (is_drop && (rd_pin == '0)));
	assign wb_now   = act && (is_flush || ((op_q == OP_INVAL) && rd_dirty));
	assign ev_stall = wb_now && pend_v_q && out_v_q;
	assign ev_go    = cmd.scan_ev && !ev_stall;
	assign load_scan = ev_go && wb_now && pend_v_q;

	// decision
	logic full, add_ok, evict;
	logic [ST_W-1:0] status_d;

	assign full   = (occ_q == OCC_W'(ENTRIES));
	assign add_ok = (op_q == OP_ADD) && !found_q && (!full || vfound_q);
	assign evict  = add_ok && full;

	always_comb begin
		status_d = ST_OK;
		if (key_op && !found_q)
			status_d = ST_MISS;
		else if ((op_q == OP_ADD) && found_q)
			status_d = ST_PRESENT;
		else if ((op_q == OP_ADD) && full && !vfound_q)
			status_d = ST_NOROOM;
	end

	assign sts.idx_last = (idx_q == IDX_W'(ENTRIES - 1));
	assign sts.ev_stall = ev_stall;
	assign sts.need_upd = (key_op && found_q) || add_ok || (is_drop && (total_q != '0));
	assign sts.need_ins = add_ok;
	assign sts.out_free = !out_v_q;

	// age remap table entry for age k
	logic [AGE_W:0] k_x, ref_x, remap_x;

	assign k_x   = {1'b0, idx_q};
	assign ref_x = {1'b0, ref_age_q};

	always_comb begin
		case (op_q)
			OP_GET:              remap_x = (k_x < ref_x) ? k_x + AGE_ONE : k_x;
			OP_ADD:              remap_x = (evict_q && (k_x > ref_x)) ? k_x : k_x + AGE_ONE;
			OP_INVAL, OP_DISCARD: remap_x = k_x - run_q;
			default:             remap_x = k_x;
		endcase
	end

	// per-entry update
	logic                u_dirty;
	logic [PIN_BITS-1:0] u_pin;
	logic [AGE_W-1:0]    u_age;

	always_comb begin
		u_dirty = rd_dirty;
		u_pin   = rd_pin;
		u_age   = rdr_q;
		if (idx_q == tgt_q) begin
			case (op_q)
				OP_GET: begin
					u_age = '0;
					if (rd_pin != PIN_MAX)
						u_pin = rd_pin + PIN_ONE;
				end
				OP_PUT: begin
					if (rd_pin != '0)
						u_pin = rd_pin - PIN_ONE;
				end
				OP_MARK:  u_dirty = 1'b1;
				OP_CLEAR: u_dirty = 1'b0;
				default:  u_dirty = rd_dirty;
			endcase
		end
	end

	// meta write port
	logic              flush_wr, mw_en;
	logic [IDX_W-1:0]  mw_addr;
	logic [META_W-1:0] mw_data;

	assign flush_wr = ev_go && act && is_flush;

	always_comb begin
		mw_en   = 1'b0;
		mw_addr = idx_q;
		mw_data = {1'b0, rd_pin, rd_age};
		if (flush_wr) begin
			mw_en = 1'b1;
		end else if (cmd.upd_wr && ent_v) begin
			mw_en   = 1'b1;
			mw_data = {u_dirty, u_pin, u_age};
		end else if (cmd.ins) begin
			mw_en   = 1'b1;
			mw_addr = tgt_q;
			mw_data = {1'b0, PIN_ONE, {AGE_W{1'b0}}};
		end
	end

	always_ff @(posedge clk) begin
		if (mw_en)
			meta_mem[mw_addr] <= mw_data;
		if (cmd.scan_rd || cmd.upd_rd)
			rdm_q <= meta_mem[idx_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.ins)
			key_mem[tgt_q] <= {fs_q, file_q, page_q, frame_q};
		if (cmd.scan_rd)
			rdk_q <= key_mem[idx_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.sweep)
			remap_mem[idx_q] <= remap_x[AGE_W-1:0];
		if (cmd.upd_map)
			rdr_q <= remap_mem[rd_age];
	end

	// request latch and scan captures (payload)
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			op_q    <= op;
			fs_q    <= fs_id;
			file_q  <= file_id;
			page_q  <= page_num;
			frame_q <= frame;
		end
		if (ev_go && kh && !found_q) begin
			sidx_q   <= idx_q;
			sage_q   <= rd_age;
			hframe_q <= rd_frame;
		end
		if (ev_go && !ent_v && !free_found_q)
			free_idx_q <= idx_q;
		if (ev_go && ent_v && (rd_pin == '0) && (!vfound_q || (rd_age > vage_q))) begin
			vidx_q   <= idx_q;
			vage_q   <= rd_age;
			vdirty_q <= rd_dirty;
			vkey_q   <= rdk_q;
		end
		if (cmd.decide) begin
			status_q  <= status_d;
			evict_q   <= evict;
			tgt_q     <= evict ? vidx_q : ((op_q == OP_ADD) ? free_idx_q : sidx_q);
			ref_age_q <= evict ? vage_q : sage_q;
		end
		if (ev_go && wb_now) begin
			pend_key_q  <= rdk_q;
			pend_done_q <= total_q + DONE_ONE;
		end else if (cmd.decide && evict && vdirty_q) begin
			pend_key_q  <= vkey_q;
			pend_done_q <= DONE_ONE;
		end
		if (load_scan) begin
			out_kind_q <= KIND_WB;
			out_st_q   <= ST_OK;
			out_key_q  <= pend_key_q;
			out_done_q <= pend_done_q;
			out_last_q <= 1'b0;
		end else if (cmd.fin) begin
			out_last_q <= 1'b1;
			out_done_q <= total_q;
			if (pend_v_q) begin
				out_kind_q <= KIND_WB;
				out_st_q   <= ST_OK;
				out_key_q  <= pend_key_q;
			end else begin
				out_kind_q <= KIND_STATUS;
				out_st_q   <= status_q;
				out_key_q  <= {{(KEY_W - ID_W){1'b0}},
					((op_q == OP_GET) && found_q) ? hframe_q : {ID_W{1'b0}}};
			end
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q        <= '0;
			valid_q      <= '0;
			occ_q        <= '0;
			found_q      <= 1'b0;
			free_found_q <= 1'b0;
			vfound_q     <= 1'b0;
			total_q      <= '0;
			dmask_q      <= '0;
			run_q        <= '0;
			pend_v_q     <= 1'b0;
			out_v_q      <= 1'b0;
		end else begin
			if (cmd.idx_clr)
				idx_q <= '0;
			else if (cmd.idx_inc)
				idx_q <= idx_q + IDX_W'(1);

			if (cmd.take) begin
				found_q      <= 1'b0;
				free_found_q <= 1'b0;
				vfound_q     <= 1'b0;
				total_q      <= '0;
				dmask_q      <= '0;
				run_q        <= '0;
				pend_v_q     <= 1'b0;
			end

			if (ev_go && kh)
				found_q <= 1'b1;
			if (ev_go && !ent_v)
				free_found_q <= 1'b1;
			if (ev_go && ent_v && (rd_pin == '0))
				vfound_q <= 1'b1;

			if (ev_go && act) begin
				total_q <= total_q + DONE_ONE;
				if (is_drop) begin
					valid_q[idx_q]  <= 1'b0;
					dmask_q[rd_age] <= 1'b1;
					occ_q           <= occ_q - OCC_W'(1);
				end
			end
			if (ev_go && wb_now)
				pend_v_q <= 1'b1;

			if (cmd.decide && evict) begin
				total_q <= DONE_ONE;
				if (vdirty_q)
					pend_v_q <= 1'b1;
			end

			if (cmd.sweep && dmask_q[idx_q])
				run_q <= run_q + AGE_ONE;

			if (cmd.ins) begin
				valid_q[tgt_q] <= 1'b1;
				if (!evict_q)
					occ_q <= occ_q + OCC_W'(1);
			end

			if (out_v_q && out_ready)
				out_v_q <= 1'b0;
			if (load_scan || cmd.fin)
				out_v_q <= 1'b1;
		end
	end

	assign out_valid  = out_v_q;
	assign kind       = out_kind_q;
	assign status     = out_st_q;
	assign {out_fs_id, out_file_id, out_page_num, out_frame} = out_key_q;
	assign done_count = out_done_q;
	assign last       = out_last_q;

	`PLC_CHECK(a_occ_range, occ_q <= OCC_W'(ENTRIES), "occupancy beyond table size")
	`PLC_CHECK_IMP(a_out_load_free, load_scan || cmd.fin, !out_v_q, "output overwritten")
	`PLC_CHECK_IMP(a_ins_free_slot, cmd.ins && !evict_q, !valid_q[tgt_q], "insert over live slot")
	`PLC_CHECK_NXT(a_fin_shows, cmd.fin, out_v_q && out_last_q, "final beat not presented")
endmodule

/* rtl/core/pinned_lru_page_cache.sv */
// Pinned LRU page cache: a table of ENTRIES pages keyed by (fs_id, file_id, page_num).
// Request channel: in_valid/in_ready carry op plus key and frame; one request at a time.
// Result channel: out_valid/out_ready; each request yields one or more beats, the final
// one with last=1. Writeback beats have kind=1; otherwise a single status beat.
// Every request walks the table slot by slot through single-port key/meta memories:
//   lookup scan, then decide and result;
//   hits of get, put, mark and clear, a successful add, and invalidate/discard that drop
//   something add an age remap sweep and a meta rewrite pass; an add also inserts.
// A new request is taken as soon as the previous one has placed its last beat in the
// output register, even while that beat waits for out_ready.
// A stalled receiver stalls a flush or invalidate walk only when a new writeback
// beat is ready while one is held and a beat sits in the output register.
// Reset clears the valid bits, occupancy and the handshakes; key, frame and age memories
// are left as they are and only read behind a valid bit.
module pinned_lru_page_cache #(
	parameter int ENTRIES  = 64,
	parameter int PIN_BITS = 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [plc_pkg::OP_W-1:0]    op,
	input  logic [plc_pkg::FS_W-1:0]    fs_id,
	input  logic [plc_pkg::ID_W-1:0]    file_id,
	input  logic [plc_pkg::ID_W-1:0]    page_num,
	input  logic [plc_pkg::ID_W-1:0]    frame,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic                        kind,
	output logic [plc_pkg::ST_W-1:0]    status,
	output logic [plc_pkg::FS_W-1:0]    out_fs_id,
	output logic [plc_pkg::ID_W-1:0]    out_file_id,
	output logic [plc_pkg::ID_W-1:0]    out_page_num,
	output logic [plc_pkg::ID_W-1:0]    out_frame,
	output logic [plc_pkg::DONE_W-1:0]  done_count,
	output logic                        last
);
	import plc_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// sequencer: scan, decide, remap sweep, rewrite, insert, result
	plc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// table memories, scan captures and the output register
	plc_datapath #(
		.ENTRIES  (ENTRIES),
		.PIN_BITS (PIN_BITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.op             (op),
		.fs_id          (fs_id),
		.file_id        (file_id),
		.page_num       (page_num),
		.frame          (frame),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.kind           (kind),
		.status         (status),
		.out_fs_id      (out_fs_id),
		.out_file_id    (out_file_id),
		.out_page_num   (out_page_num),
		.out_frame      (out_frame),
		.done_count     (done_count),
		.last           (last)
	);
endmodule

/* dv/testbench.sv */
`timescale 1ns / 100ps

module testbench;
	import plc_pkg::*;

	localparam int SLOTS   = 64;
	localparam int PIN_TOP = 255;

	// One result beat as the cache should present it.
	typedef struct {
		logic        kind;
		logic [1:0]  status;
		logic [15:0] fs;
		logic [31:0] file;
		logic [31:0] page;
		logic [31:0] frame;
		logic [6:0]  done;
		logic        last;
	} beat_t;

	// Shadow copy of the page table plus the queue of beats it predicts.
	class page_table_board;
		bit          used[SLOTS];
		logic [15:0] tag_fs[SLOTS];
		logic [31:0] tag_file[SLOTS];
		logic [31:0] tag_page[SLOTS];
		logic [31:0] held_frame[SLOTS];
		bit          dirty[SLOTS];
		int          pins[SLOTS];
		int          age[SLOTS];
		int          fill;
		beat_t       awaited[$];
		int          errors;

		function new();
			for (int i = 0; i < SLOTS; i++) begin
				used[i] = 0;
				dirty[i] = 0;
				pins[i] = 0;
			end
			fill = 0;
			errors = 0;
		endfunction

		function int find_slot(logic [15:0] fs, logic [31:0] file, logic [31:0] page);
			for (int i = 0; i < SLOTS; i++)
				if (used[i] && tag_fs[i] == fs && tag_file[i] == file && tag_page[i] == page)
					return i;
			return -1;
		endfunction

		function beat_t status_beat(logic [1:0] st, logic [31:0] fr, logic [6:0] dn);
			beat_t b;
			b = '{kind: KIND_STATUS, status: st, fs: '0, file: '0, page: '0,
			      frame: fr, done: dn, last: 1'b1};
			return b;
		endfunction

		function beat_t writeback_beat(int s, logic [6:0] dn);
			beat_t b;
			b = '{kind: KIND_WB, status: ST_OK, fs: tag_fs[s], file: tag_file[s],
			      page: tag_page[s], frame: held_frame[s], done: dn, last: 1'b0};
			return b;
		endfunction

		function void drop(int s);
			int a;
			a = age[s];
			used[s] = 0;
			dirty[s] = 0;
			pins[s] = 0;
			for (int j = 0; j < SLOTS; j++)
				if (used[j] && age[j] > a)
					age[j]--;
			if (fill > 0)
				fill--;
		endfunction

		// Runs one accepted request through the shadow table.
		function void note_request(logic [3:0] op, logic [15:0] fs, logic [31:0] file,
		                           logic [31:0] page, logic [31:0] fr);
			beat_t out[$];
			int s, victim, slot, a, total;
			bit wb;
			total = 0;
			wb = 0;
			s = find_slot(fs, file, page);
			case (op)
				OP_ADD: begin
					if (s >= 0) begin
						out.push_back(status_beat(ST_PRESENT, '0, '0));
					end else begin
						victim = -1;
						if (fill >= SLOTS) begin
							for (int i = 0; i < SLOTS; i++)
								if (used[i] && pins[i] == 0 &&
								    (victim < 0 || age[i] > age[victim]))
									victim = i;
							if (victim < 0) begin
								out.push_back(status_beat(ST_NOROOM, '0, '0));
							end else begin
								if (dirty[victim]) begin
									out.push_back(writeback_beat(victim, 7'd1));
									wb = 1;
								end
								drop(victim);
								total = 1;
							end
						end
						if (fill < SLOTS) begin
							slot = 0;
							while (used[slot])
								slot++;
							tag_fs[slot] = fs;
							tag_file[slot] = file;
							tag_page[slot] = page;
							held_frame[slot] = fr;
							dirty[slot] = 0;
							pins[slot] = 1;
							for (int j = 0; j < SLOTS; j++)
								if (used[j])
									age[j]++;
							used[slot] = 1;
							age[slot] = 0;
							fill++;
							if (wb)
								out[0].last = 1'b1;
							else
								out.push_back(status_beat(ST_OK, '0, 7'(total)));
						end
					end
				end
				OP_GET, OP_PUT, OP_MARK, OP_CLEAR: begin
					if (s < 0) begin
						out.push_back(status_beat(ST_MISS, '0, '0));
					end else if (op == OP_GET) begin
						a = age[s];
						for (int j = 0; j < SLOTS; j++)
							if (used[j] && j != s && age[j] < a)
								age[j]++;
						age[s] = 0;
						if (pins[s] < PIN_TOP)
							pins[s]++;
						out.push_back(status_beat(ST_OK, held_frame[s], '0));
					end else begin
						if (op == OP_PUT && pins[s] > 0)
							pins[s]--;
						if (op == OP_MARK)
							dirty[s] = 1;
						if (op == OP_CLEAR)
							dirty[s] = 0;
						out.push_back(status_beat(ST_OK, '0, '0));
					end
				end
				OP_FLUSH_FILE, OP_FLUSH_ALL, OP_INVAL, OP_DISCARD: begin
					// walks go in slot order
					for (int i = 0; i < SLOTS; i++) begin
						if (!used[i])
							continue;
						if (op != OP_FLUSH_ALL && (tag_fs[i] != fs || tag_file[i] != file))
							continue;
						if (op == OP_FLUSH_FILE || op == OP_FLUSH_ALL) begin
							if (dirty[i]) begin
								total++;
								out.push_back(writeback_beat(i, 7'(total)));
								dirty[i] = 0;
							end
						end else if (pins[i] == 0) begin
							total++;
							if (op == OP_INVAL && dirty[i])
								out.push_back(writeback_beat(i, 7'(total)));
							drop(i);
						end
					end
					if (out.size() == 0) begin
						out.push_back(status_beat(ST_OK, '0, 7'(total)));
					end else begin
						out[out.size()-1].done = 7'(total);
						out[out.size()-1].last = 1'b1;
					end
				end
				default: out.push_back(status_beat(ST_OK, '0, '0));
			endcase
			foreach (out[k])
				awaited.push_back(out[k]);
		endfunction

		function void check_beat(beat_t got);
			beat_t exp_b;
			if (awaited.size() == 0) begin
				$error("unexpected result beat, kind %0d status %0d", got.kind, got.status);
				errors++;
				return;
			end
			exp_b = awaited.pop_front();
			if (got.kind !== exp_b.kind) begin
				$error("kind: expected %0d, got %0d", exp_b.kind, got.kind); errors++;
			end
			if (got.status !== exp_b.status) begin
				$error("status: expected %0d, got %0d", exp_b.status, got.status); errors++;
			end
			if (got.fs !== exp_b.fs) begin
				$error("out_fs_id: expected %h, got %h", exp_b.fs, got.fs); errors++;
			end
			if (got.file !== exp_b.file) begin
				$error("out_file_id: expected %h, got %h", exp_b.file, got.file); errors++;
			end
			if (got.page !== exp_b.page) begin
				$error("out_page_num: expected %h, got %h", exp_b.page, got.page); errors++;
			end
			if (got.frame !== exp_b.frame) begin
				$error("out_frame: expected %h, got %h", exp_b.frame, got.frame); errors++;
			end
			if (got.done !== exp_b.done) begin
				$error("done_count: expected %0d, got %0d", exp_b.done, got.done); errors++;
			end
			if (got.last !== exp_b.last) begin
				$error("last: expected %0d, got %0d", exp_b.last, got.last); errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [3:0]  op;
	logic [15:0] fs_id;
	logic [31:0] file_id;
	logic [31:0] page_num;
	logic [31:0] frame;
	logic        out_valid;
	logic        out_ready;
	logic        kind;
	logic [1:0]  status;
	logic [15:0] out_fs_id;
	logic [31:0] out_file_id;
	logic [31:0] out_page_num;
	logic [31:0] out_frame;
	logic [6:0]  done_count;
	logic        last;

	page_table_board board;

	// idle percentages for the current phase
	int sender_idle_pct;
	int recv_stall_pct;
	// set by stimulus; receiver then holds off on its own count
	bit hold_off_req;

	pinned_lru_page_cache dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.op(op), .fs_id(fs_id), .file_id(file_id), .page_num(page_num), .frame(frame),
		.out_valid(out_valid), .out_ready(out_ready),
		.kind(kind), .status(status), .out_fs_id(out_fs_id), .out_file_id(out_file_id),
		.out_page_num(out_page_num), .out_frame(out_frame),
		.done_count(done_count), .last(last)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Safety net: far beyond the slowest legal run.
	initial begin
		#2000000;
		$display("testbench: FAIL");
		$finish;
	end

	// Receiver: random back-pressure, plus one long hold-off when asked.
	initial begin
		int hold_left;
		hold_left = 0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off_req && hold_left == 0) begin
				hold_left = 1500;
				hold_off_req = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
			end
		end
	end

	// Result monitor, sampled on the rising edge.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			board.check_beat('{kind: kind, status: status, fs: out_fs_id,
			                   file: out_file_id, page: out_page_num, frame: out_frame,
			                   done: done_count, last: last});
	end

	// Offers one request beat and waits for the accept edge. Valid stays high
	// across back-to-back beats; it only drops when the sender idles.
	task automatic send_req(logic [3:0] o, logic [15:0] f, logic [31:0] fl,
	                        logic [31:0] pg, logic [31:0] fr);
		if ($urandom_range(0, 99) < sender_idle_pct) begin
			@(negedge clk);
			in_valid <= 1'b0;
			while ($urandom_range(0, 99) < sender_idle_pct)
				@(negedge clk);
		end
		@(negedge clk);
		op <= o;
		fs_id <= f;
		file_id <= fl;
		page_num <= pg;
		frame <= fr;
		in_valid <= 1'b1;
		do
			@(posedge clk);
		while (!in_ready);
		board.note_request(o, f, fl, pg, fr);
	endtask

	// Random request: mostly keys from a small pool so hits, fills and evictions
	// happen; a little noise with wild keys and random op codes, some undefined.
	task automatic send_random();
		logic [3:0]  o;
		logic [15:0] f;
		logic [31:0] fl;
		logic [31:0] pg;
		int r;
		r = $urandom_range(0, 99);
		f = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
		fl = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
		pg = $urandom_range(0, 23);
		if (r < 35)      o = OP_ADD;
		else if (r < 50) o = OP_GET;
		else if (r < 70) o = OP_PUT;
		else if (r < 80) o = OP_MARK;
		else if (r < 85) o = OP_CLEAR;
		else if (r < 89) o = OP_FLUSH_FILE;
		else if (r < 91) o = OP_FLUSH_ALL;
		else if (r < 94) o = OP_INVAL;
		else if (r < 97) o = OP_DISCARD;
		else begin
			o = 4'($urandom_range(0, 15));
			f = 16'($urandom());
			fl = $urandom();
			pg = $urandom();
		end
		send_req(o, f, fl, pg, $urandom());
	endtask

	initial begin
		board = new();
		sender_idle_pct = 0;
		recv_stall_pct = 0;
		hold_off_req = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		op = '0;
		fs_id = '0;
		file_id = '0;
		page_num = '0;
		frame = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: every op, misses, duplicates, pin edge cases.
		send_req(OP_ADD, 16'h0, 32'h0, 32'h0, 32'h0);
		send_req(OP_ADD, 16'h0, 32'h0, 32'h0, 32'h5);               // duplicate
		send_req(OP_GET, 16'h0, 32'h0, 32'h0, 32'h0);               // hit
		send_req(OP_GET, 16'hFFFF, '1, '1, '1);                    // miss
		send_req(OP_PUT, 16'h0, 32'h0, 32'h0, 32'h0);
		send_req(OP_PUT, 16'h0, 32'h0, 32'h0, 32'h0);
		send_req(OP_PUT, 16'h0, 32'h0, 32'h0, 32'h0);               // already unpinned
		send_req(OP_PUT, 16'hFFFF, '1, '1, '0);                    // miss
		send_req(OP_MARK, 16'hFFFF, '1, '1, '0);                   // miss
		send_req(OP_CLEAR, 16'hFFFF, '1, '1, '0);                  // miss
		send_req(OP_ADD, 16'hFFFF, '1, '1, '1);
		send_req(OP_MARK, 16'hFFFF, '1, '1, '0);
		send_req(OP_FLUSH_FILE, 16'hFFFF, '1, '0, '0);
		send_req(OP_MARK, 16'h0, 32'h0, 32'h0, 32'h0);
		send_req(OP_CLEAR, 16'h0, 32'h0, 32'h0, 32'h0);
		send_req(OP_MARK, 16'h0, 32'h0, 32'h0, 32'h0);
		send_req(OP_MARK, 16'hFFFF, '1, '1, '0);
		send_req(OP_FLUSH_ALL, 16'h0, 32'h0, 32'h0, 32'h0);
		send_req(OP_MARK, 16'h0, 32'h0, 32'h0, 32'h0);
		send_req(OP_MARK, 16'hFFFF, '1, '1, '0);
		send_req(OP_INVAL, 16'h0, 32'h0, 32'h0, 32'h0);             // drops with writeback
		send_req(OP_INVAL, 16'hFFFF, '1, '0, '0);                  // pinned, kept
		send_req(OP_DISCARD, 16'hFFFF, '1, '0, '0);                // pinned, kept
		send_req(OP_PUT, 16'hFFFF, '1, '1, '0);
		send_req(OP_DISCARD, 16'hFFFF, '1, '0, '0);                // dropped
		send_req(4'd9, 16'h0, 32'h0, 32'h0, 32'h0);
		send_req(4'd15, 16'h0, 32'h0, 32'h0, 32'h0);

		// Fill the table with pinned pages, then hit the no-room and eviction cases.
		for (int i = 0; i < SLOTS; i++)
			send_req(OP_ADD, 16'h1234, 32'hABCD, i, $urandom());
		send_req(OP_ADD, 16'h1234, 32'hABCD, 32'd100, $urandom()); // all pinned
		send_req(OP_PUT, 16'h1234, 32'hABCD, 32'd5, '0);
		send_req(OP_PUT, 16'h1234, 32'hABCD, 32'd9, '0);
		send_req(OP_MARK, 16'h1234, 32'hABCD, 32'd5, '0);
		send_req(OP_GET, 16'h1234, 32'hABCD, 32'd9, '0);
		send_req(OP_PUT, 16'h1234, 32'hABCD, 32'd9, '0);
		send_req(OP_ADD, 16'h1234, 32'hABCD, 32'd101, $urandom()); // evicts dirty 5
		send_req(OP_ADD, 16'h1234, 32'hABCD, 32'd102, $urandom()); // evicts clean 9
		for (int i = 0; i < SLOTS; i++) begin
			if (i % 8 == 0)
				send_req(OP_MARK, 16'h1234, 32'hABCD, i, '0);
			send_req(OP_PUT, 16'h1234, 32'hABCD, i, '0);
		end
		send_req(OP_PUT, 16'h1234, 32'hABCD, 32'd101, '0);
		send_req(OP_PUT, 16'h1234, 32'hABCD, 32'd102, '0);
		send_req(OP_INVAL, 16'h1234, 32'hABCD, '0, '0);            // long writeback walk

		// Random phases with different idling; the long hold-off rides on phase two.
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin sender_idle_pct = 0;  recv_stall_pct = 0;  hold_off_req = 1; end
				2: begin sender_idle_pct = 50; recv_stall_pct = 50; end
				default: begin sender_idle_pct = 29; recv_stall_pct = 29; end
			endcase
			if (ph == 2) begin
				for (int i = 0; i < 18; i++) begin
					sender_idle_pct = 50; recv_stall_pct = 0;
					send_random();
				end
				sender_idle_pct = 0; recv_stall_pct = 50;
				for (int i = 0; i < 17; i++)
					send_random();
			end else begin
				for (int i = 0; i < 35; i++)
					send_random();
			end
			// a mark and a flush-all after each phase to get writeback walks
			send_req(OP_MARK, 16'h0, 32'h0, 32'd3, '0);
			send_req(OP_FLUSH_ALL, 16'h0, 32'h0, 32'h0, 32'h0);
		end

		@(negedge clk);
		in_valid <= 1'b0;
		while (board.awaited.size() != 0)
			@(posedge clk);
		repeat (400) @(posedge clk);
		if (board.errors == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end
endmodule
